FILE: rtl/rsgsh_pkg.sv
// Constants, register indexes and helpers of the reference-signal hopping unit.
`timescale 1ns / 1ps
`default_nettype none

package rsgsh_pkg;

  localparam int SKIP_LENGTH     = 1600;
  localparam int RB_SUBCARRIERS  = 12;
  localparam int SLOTS_PER_FRAME = 20;

  localparam int NUM_GROUPS      = 30;
  localparam int LONG_RS_RBS     = 6;

  // x2 runs alone over the first SKIP_LENGTH-31 steps
  localparam int FF_STEPS        = SKIP_LENGTH - 31;
  // highest Gold index used: the last bit of slot SLOTS_PER_FRAME-1 in group mode
  localparam int GOLD_LAST_MAX   = 8 * SLOTS_PER_FRAME - 1;
  localparam int CNT_MAX         = (FF_STEPS > GOLD_LAST_MAX) ? FF_STEPS : GOLD_LAST_MAX;
  localparam int CNT_W           = $clog2(CNT_MAX + 1);

  localparam int SLOT_W          = 5;
  localparam int ID_W            = 9;
  localparam int DSS_W           = 5;
  localparam int LEN_W           = 12;
  localparam int SEL_W           = 2;
  localparam int GRP_W           = 5;
  localparam int LFSR_W          = 31;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 12;

  localparam logic [LFSR_W-1:0] X1_PRESET_1600 = 31'h54D21B24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_ID      = 3'd0,
    REG_SEQ_SHIFT    = 3'd1,
    REG_GROUP_HOP_EN = 3'd2,
    REG_SEQ_HOP_EN   = 3'd3,
    REG_RS_LENGTH    = 3'd4,
    REG_ID_SELECT    = 3'd5,
    REG_CTRL_VID     = 3'd6,
    REG_SHARED_VID   = 3'd7
  } cfg_reg_t;

  localparam logic [SEL_W-1:0] ID_SEL_CTRL   = 2'd1;
  localparam logic [SEL_W-1:0] ID_SEL_SHARED = 2'd2;

  // x1 state after FF_STEPS steps from seed 1, evaluated at elaboration
  function automatic logic [LFSR_W-1:0] x1_preset_calc();
    logic [LFSR_W-1:0] x;
    x = LFSR_W'(1);
    for (int n = 0; n < FF_STEPS; n++) begin
      x = {x[3] ^ x[0], x[LFSR_W-1:1]};
    end
    return x;
  endfunction

  localparam logic [LFSR_W-1:0] X1_PRESET =
    (SKIP_LENGTH == 1600) ? X1_PRESET_1600 : x1_preset_calc();

endpackage

`default_nettype wire

FILE: rtl/rs_group_sequence_hopping_unit.sv
// Uplink reference-signal group and base-sequence number generator.
//
// Usage: write the eight configuration registers through cfg_valid/cfg_ready
// (cfg_index selects the register, cfg_data carries the value) while the block
// is idle; cfg_ready is always high. Each slot transaction on in_valid/in_ready
// yields exactly one result transaction on out_valid/out_ready carrying
// group_number (u) and base_seq_number (v).
// Each slot runs these steps in order: serial mod-30 reduction of the
// identities and mod-20 reduction of the slot, x2 fast-forward, then the
// Gold bits up to the last one needed, then serial mod-30 reduction of u.
// A new slot is taken only once the previous result has gone to the output
// register; the single Gold-sequence LFSR pair serves one slot at a time.
// in_ready is high whenever no slot is in work, also while a result waits in
// the output register. If the receiver stalls, the next slot still runs and
// holds in its final reduction state until the output register frees.
// Synchronous reset clears the configuration registers to 0, returns the
// control to idle and drops any slot in work and any pending result.
`timescale 1ns / 1ps
`default_nettype none

module rs_group_sequence_hopping_unit (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [rsgsh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [rsgsh_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [rsgsh_pkg::SLOT_W-1:0]         slot,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [rsgsh_pkg::GRP_W-1:0]          group_number,
  output logic                                 base_seq_number
);
  import rsgsh_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIV    = 5'b00010,
    S_FF     = 5'b00100,
    S_GOLD   = 5'b01000,
    S_REDUCE = 5'b10000
  } state_t;

  localparam int SLOT_CMP_W = 7;
  localparam int QUO_W      = 5;
  localparam int SUM_W      = 6;
  localparam int ACC_W      = 8;

  state_t state;

  // configuration registers
  logic [ID_W-1:0]  cell_id;
  logic [DSS_W-1:0] seq_shift;
  logic             group_hop_en;
  logic             seq_hop_en;
  logic [LEN_W-1:0] rs_length;
  logic [SEL_W-1:0] id_select;
  logic [ID_W-1:0]  ctrl_vid;
  logic [ID_W-1:0]  shared_vid;

  // per-slot working registers
  logic [SLOT_W-1:0] ns;
  logic [ID_W-1:0]   rem_c;
  logic [QUO_W-1:0]  quo_c;
  logic [ID_W-1:0]   rem_n;
  logic              gh;
  logic              v_en;
  logic [LFSR_W-1:0] x1;
  logic [LFSR_W-1:0] x2;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  first;
  logic [CNT_W-1:0]  last;
  logic [ACC_W-1:0]  acc;
  logic              v_bit;

  logic              fb1;
  logic              fb2;
  logic              gold_bit;
  logic [ACC_W-1:0]  acc_next;
  logic              ns_wrap;
  logic              c_big;
  logic              n_big;
  logic [SUM_W-1:0]  ss_sum;
  logic [SUM_W-1:0]  ss_mod;
  logic [ID_W-1:0]   n_id;
  logic              long_rs;
  logic              load_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    if (id_select == ID_SEL_CTRL) begin
      n_id = ctrl_vid;
    end else if (id_select == ID_SEL_SHARED) begin
      n_id = shared_vid;
    end else begin
      n_id = cell_id;
    end
  end

  assign long_rs = ({1'b0, rs_length} >= (LEN_W+1)'(LONG_RS_RBS * RB_SUBCARRIERS));

  assign ns_wrap = ({{(SLOT_CMP_W-SLOT_W){1'b0}}, ns} >= SLOT_CMP_W'(SLOTS_PER_FRAME));
  assign c_big   = (rem_c >= ID_W'(NUM_GROUPS));
  assign n_big   = (rem_n >= ID_W'(NUM_GROUPS));

  // result leaves the reduction once u is below 30 and the output register is free
  assign load_out = (state == S_REDUCE) && !n_big && (!out_valid || out_ready);

  // (cell_id mod 30) + seq_shift stays below 61: two subtractions at most
  assign ss_sum = SUM_W'(rem_c) + SUM_W'(seq_shift);
  always_comb begin
    if (ss_sum >= SUM_W'(2 * NUM_GROUPS)) begin
      ss_mod = ss_sum - SUM_W'(2 * NUM_GROUPS);
    end else if (ss_sum >= SUM_W'(NUM_GROUPS)) begin
      ss_mod = ss_sum - SUM_W'(NUM_GROUPS);
    end else begin
      ss_mod = ss_sum;
    end
  end

  assign fb1      = x1[3] ^ x1[0];
  assign fb2      = x2[3] ^ x2[2] ^ x2[1] ^ x2[0];
  assign gold_bit = fb1 ^ fb2;
  assign acc_next = (cnt >= first) ? {gold_bit, acc[ACC_W-1:1]} : acc;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_id      <= '0;
      seq_shift    <= '0;
      group_hop_en <= 1'b0;
      seq_hop_en   <= 1'b0;
      rs_length    <= '0;
      id_select    <= '0;
      ctrl_vid     <= '0;
      shared_vid   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CELL_ID:      cell_id      <= cfg_data[ID_W-1:0];
        REG_SEQ_SHIFT:    seq_shift    <= cfg_data[DSS_W-1:0];
        REG_GROUP_HOP_EN: group_hop_en <= cfg_data[0];
        REG_SEQ_HOP_EN:   seq_hop_en   <= cfg_data[0];
        REG_RS_LENGTH:    rs_length    <= cfg_data[LEN_W-1:0];
        REG_ID_SELECT:    id_select    <= cfg_data[SEL_W-1:0];
        REG_CTRL_VID:     ctrl_vid     <= cfg_data[ID_W-1:0];
        REG_SHARED_VID:   shared_vid   <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!ns_wrap && !c_big && !n_big) begin
            state <= S_FF;
          end
        end
        S_FF: begin
          if (cnt == CNT_W'(FF_STEPS)) begin
            state <= S_GOLD;
          end
        end
        S_GOLD: begin
          if (cnt == last) begin
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ns    <= slot;
        rem_c <= cell_id;
        quo_c <= '0;
        rem_n <= n_id;
        gh    <= group_hop_en;
        v_en  <= seq_hop_en && !group_hop_en && long_rs;
      end
      S_DIV: begin
        // subtract-and-count reduction by 30 (by 20 for the slot), one step per cycle
        if (ns_wrap) begin
          ns <= ns - SLOT_W'(SLOTS_PER_FRAME);
        end
        if (c_big) begin
          rem_c <= rem_c - ID_W'(NUM_GROUPS);
          quo_c <= quo_c + QUO_W'(1);
        end
        if (n_big) begin
          rem_n <= rem_n - ID_W'(NUM_GROUPS);
        end
        x1  <= X1_PRESET;
        cnt <= '0;
        acc <= '0;
        if (gh) begin
          x2    <= LFSR_W'(quo_c);
          first <= CNT_W'({ns, 3'b000});
          last  <= CNT_W'({ns, 3'b111});
        end else begin
          x2    <= LFSR_W'({quo_c, ss_mod[GRP_W-1:0]});
          first <= CNT_W'(ns);
          last  <= CNT_W'(ns);
        end
      end
      S_FF: begin
        if (cnt == CNT_W'(FF_STEPS)) begin
          cnt <= '0;
        end else begin
          x2  <= {fb2, x2[LFSR_W-1:1]};
          cnt <= cnt + CNT_W'(1);
        end
      end
      S_GOLD: begin
        x1  <= {fb1, x1[LFSR_W-1:1]};
        x2  <= {fb2, x2[LFSR_W-1:1]};
        acc <= acc_next;
        cnt <= cnt + CNT_W'(1);
        if (cnt == first) begin
          v_bit <= gold_bit;
        end
        // fold the hopping pattern into the shift: (f_gh + f_ss) mod 30
        if (cnt == last && gh) begin
          rem_n <= ID_W'(acc_next) + rem_n;
        end
      end
      S_REDUCE: begin
        if (n_big) begin
          rem_n <= rem_n - ID_W'(NUM_GROUPS);
        end else if (!out_valid || out_ready) begin
          group_number    <= rem_n[GRP_W-1:0];
          base_seq_number <= v_en && v_bit;
        end
      end
      default: ;
    endcase
  end

  a_group_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (group_number < GRP_W'(NUM_GROUPS)))
    else $error("group number out of range");

  a_gold_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_GOLD) |-> (cnt <= last) && (first <= last))
    else $error("Gold index ran past the last needed bit");

  a_ff_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_FF) ##1 (state == S_GOLD) |-> ($past(cnt) == CNT_W'(FF_STEPS)))
    else $error("x2 fast-forward left early");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DIV))
    else $error("accepted slot did not start");

endmodule

`default_nettype wire

FILE: bench/hop_number_checker.sv
// Watches the hopping unit's channels, predicts group and base-sequence numbers and compares.
`timescale 1ns / 1ps

module hop_number_checker (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_valid,
  input  wire                             cfg_ready,
  input  wire [rsgsh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [rsgsh_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                             in_valid,
  input  wire                             in_ready,
  input  wire [rsgsh_pkg::SLOT_W-1:0]     slot,
  input  wire                             out_valid,
  input  wire                             out_ready,
  input  wire [rsgsh_pkg::GRP_W-1:0]      group_number,
  input  wire                             base_seq_number,
  output int                              mismatches,
  output int                              pending
);
  import rsgsh_pkg::*;

  // x1 state once the first SKIP_LENGTH-31 steps are behind it
  localparam logic [LFSR_W-1:0] X1_START = 31'h54D21B24;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [GRP_W-1:0]  u;
    logic              v;
  } hop_t;

  hop_t expected_hops[$];

  int unsigned phys_id, dss, pucch, pusch, rs_len;
  logic        grp_en, seq_en;
  logic [1:0]  id_sel;

  // Pack Gold bits c(first)..c(first+count-1), LSB first.
  function automatic logic [7:0] gold_window(input logic [LFSR_W-1:0] seed,
                                             input int first, input int count);
    logic [LFSR_W-1:0] a, b;
    logic [7:0]        acc;
    logic              fa, fb;
    int                n;
    a = X1_START;
    b = seed;
    acc = '0;
    for (n = 0; n < SKIP_LENGTH - 31; n++) begin
      fb = b[3] ^ b[2] ^ b[1] ^ b[0];
      b = {fb, b[LFSR_W-1:1]};
    end
    for (n = 0; n < first + count; n++) begin
      fa = a[3] ^ a[0];
      a = {fa, a[LFSR_W-1:1]};
      fb = b[3] ^ b[2] ^ b[1] ^ b[0];
      b = {fb, b[LFSR_W-1:1]};
      if (n >= first) acc[n - first] = fa ^ fb;
    end
    return acc;
  endfunction

  function automatic hop_t predict_hop(input logic [SLOT_W-1:0] s);
    int unsigned ns, nid, fgh, seed;
    logic [7:0]  bits;
    hop_t        r;
    ns = s % SLOTS_PER_FRAME;
    case (id_sel)
      ID_SEL_CTRL:   nid = pucch;
      ID_SEL_SHARED: nid = pusch;
      default:       nid = phys_id;
    endcase
    fgh = 0;
    if (grp_en) begin
      bits = gold_window(LFSR_W'(phys_id / NUM_GROUPS), 8 * ns, 8);
      fgh = bits % NUM_GROUPS;
    end
    r.slot = s;
    r.u = GRP_W'((fgh + nid % NUM_GROUPS) % NUM_GROUPS);
    r.v = 1'b0;
    if (seq_en && !grp_en && rs_len >= LONG_RS_RBS * RB_SUBCARRIERS) begin
      seed = ((phys_id / NUM_GROUPS) << 5) + ((phys_id % NUM_GROUPS) + dss) % NUM_GROUPS;
      bits = gold_window(LFSR_W'(seed), ns, 1);
      r.v = bits[0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    hop_t want;
    if (rst) begin
      phys_id = 0; dss = 0; pucch = 0; pusch = 0; rs_len = 0;
      grp_en = 1'b0; seq_en = 1'b0; id_sel = '0;
      expected_hops.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CELL_ID:      phys_id = cfg_data[ID_W-1:0];
          REG_SEQ_SHIFT:    dss = cfg_data[DSS_W-1:0];
          REG_GROUP_HOP_EN: grp_en = cfg_data[0];
          REG_SEQ_HOP_EN:   seq_en = cfg_data[0];
          REG_RS_LENGTH:    rs_len = cfg_data[LEN_W-1:0];
          REG_ID_SELECT:    id_sel = cfg_data[SEL_W-1:0];
          REG_CTRL_VID:     pucch = cfg_data[ID_W-1:0];
          REG_SHARED_VID:   pusch = cfg_data[ID_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_hops.push_back(predict_hop(slot));
      if (out_valid && out_ready) begin
        if (expected_hops.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result u=%0d v=%0d with no slot outstanding",
                     $realtime, group_number, base_seq_number);
          mismatches++;
        end else begin
          want = expected_hops.pop_front();
          if (group_number !== want.u || base_seq_number !== want.v) begin
            if (mismatches < 10)
              $display("%0t: slot %0d expected u=%0d v=%0d, got u=%0d v=%0d",
                       $realtime, want.slot, want.u, want.v,
                       group_number, base_seq_number);
            mismatches++;
          end
        end
      end
    end
    pending <= expected_hops.size();
  end

endmodule

FILE: bench/testbench.sv
// Stimulus and verdict for the reference-signal group and sequence hopping unit.
`timescale 1ns / 1ps

module testbench;
  import rsgsh_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [SLOT_W-1:0]     slot;
  logic                  out_valid;
  logic                  out_ready;
  logic [GRP_W-1:0]      group_number;
  logic                  base_seq_number;
  int                    mismatches;
  int                    pending;
  int                    stall_left;
  int                    random_slots;
  bit                    calm;

  rs_group_sequence_hopping_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .slot(slot),
    .out_valid(out_valid), .out_ready(out_ready),
    .group_number(group_number), .base_seq_number(base_seq_number)
  );

  hop_number_checker hop_chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .slot(slot),
    .out_valid(out_valid), .out_ready(out_ready),
    .group_number(group_number), .base_seq_number(base_seq_number),
    .mismatches(mismatches), .pending(pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Mostly short pauses, now and then a long one that can span the whole slot computation.
  function automatic int idle_len(input int short_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < short_pct) return $urandom_range(1, 6);
    return $urandom_range(200, 2400);
  endfunction

  // Receiver: often stall just as a result shows up, rarely at other times.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!calm && ((out_valid && out_ready && $urandom_range(0, 99) < 35) ||
                           $urandom_range(0, 399) == 0)) begin
      out_ready <= 1'b0;
      stall_left = idle_len(75) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(input cfg_reg_t r, input int unsigned v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input int unsigned phys_id, dss, gh, sh, len, sel, pucch,
                              pusch);
    write_reg(REG_CELL_ID, phys_id);
    write_reg(REG_SEQ_SHIFT, dss);
    write_reg(REG_GROUP_HOP_EN, gh);
    write_reg(REG_SEQ_HOP_EN, sh);
    write_reg(REG_RS_LENGTH, len);
    write_reg(REG_ID_SELECT, sel);
    write_reg(REG_CTRL_VID, pucch);
    write_reg(REG_SHARED_VID, pusch);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    do @(negedge clk); while (pending != 0);
  endtask

  // Hold the slot until accepted, then drop valid; gaps start after the drop.
  task automatic send_slot(input int unsigned s);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 40) gap = idle_len(70);
    repeat (gap) @(negedge clk);
    @(negedge clk);
    in_valid <= 1'b1;
    slot <= s[SLOT_W-1:0];
    do @(posedge clk); while (!in_ready);
    @(negedge clk) in_valid <= 1'b0;
  endtask

  initial begin
    int unsigned mode, phys_id, dss, gh, sh, len, n;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    slot = '0;
    calm = 1'b0;
    random_slots = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // registers still at their reset values
    send_slot(0);
    send_slot(31);

    // group hopping, largest valid cell id, slots at and past the frame end
    wait_drain();
    program_regs(503, 0, 1, 0, 0, 0, 0, 0);
    send_slot(0);
    send_slot(19);
    send_slot(20);
    send_slot(31);
    send_slot(7);

    // out-of-range identities, selector value 3 falls back to the cell id
    wait_drain();
    program_regs(511, 0, 1, 0, 0, 3, 511, 509);
    send_slot(5);
    send_slot(13);

    // sequence hopping at exactly the long-signal threshold, top sequence shift
    wait_drain();
    program_regs(511, 31, 0, 1, LONG_RS_RBS * RB_SUBCARRIERS, 1, 511, 0);
    send_slot(0);
    send_slot(19);
    send_slot(25);

    // one subcarrier short: v held at zero
    wait_drain();
    program_regs(511, 31, 0, 1, LONG_RS_RBS * RB_SUBCARRIERS - 1, 1, 511, 0);
    send_slot(3);
    send_slot(10);

    // longest signal, shared-channel identity
    wait_drain();
    program_regs(0, 29, 0, 1, 4095, 2, 0, 509);
    send_slot(1);
    send_slot(18);

    // both hopping modes on: group hopping wins, v stays zero
    wait_drain();
    program_regs(29, 5, 1, 1, 4095, 2, 100, 509);
    send_slot(9);
    send_slot(30);

    while (random_slots < 150) begin
      wait_drain();
      mode = $urandom_range(0, 2);
      phys_id = ($urandom_range(0, 9) == 0) ? $urandom_range(504, 511)
                                            : $urandom_range(0, 503);
      dss = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 31) : $urandom_range(0, 29);
      gh = (mode == 0) ? 1 : (mode == 1) ? 0 : $urandom_range(0, 1);
      sh = (mode == 1) ? 1 : $urandom_range(0, 1);
      case ($urandom_range(0, 3))
        0:       len = LONG_RS_RBS * RB_SUBCARRIERS - 1;
        1:       len = LONG_RS_RBS * RB_SUBCARRIERS;
        default: len = $urandom_range(0, 4095);
      endcase
      if (mode == 1) len = $urandom_range(LONG_RS_RBS * RB_SUBCARRIERS, 4095);
      program_regs(phys_id, dss, gh, sh, len, $urandom_range(0, 3), $urandom_range(0, 511),
                   $urandom_range(0, 511));
      calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(5, 20);
      repeat (n) begin
        if (!calm && $urandom_range(0, 19) == 0) wait_drain();
        send_slot(($urandom_range(0, 7) == 0) ? $urandom_range(20, 31)
                                              : $urandom_range(0, 19));
        random_slots++;
      end
    end

    wait_drain();
    calm = 1'b1;
    // watch for stray results before giving the verdict
    repeat (1800) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
rtl/rsgsh_pkg.sv
rtl/rs_group_sequence_hopping_unit.sv
bench/hop_number_checker.sv
bench/testbench.sv
